// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the rate limiter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/fwrl_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed-window rate limiter package
// Table geometry, field widths, register indexes and shared types.
// ----------------------------------------------------------------------------
package fwrl_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int KEY_W         = 10;
    localparam int TIME_W        = 32;
    localparam int CNT_W         = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 16'd300;
    localparam logic [CFG_W-1:0] LIMIT_RESET  = 16'd10;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 1'd1;

    typedef enum logic
    {
        ST_CLEAR,
        ST_RUN
    } state_t;

    typedef struct packed
    {
        logic              valid;
        logic [TIME_W-1:0] start;
        logic [CNT_W-1:0]  count;
    } entry_t;

endpackage

// ===== hdl/per_key_fixed_window_rate_limiter_core.sv =====
// ----------------------------------------------------------------------------
// Per-key fixed-window rate limiter
// One table entry per key holds a valid mark, window start and pass count;
// each request reads, updates and writes back its entry.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  in       | in_valid / in_ready       | key_index, now_seconds
//  out      | out_valid / out_ready     | allowed, count_in_window
//  cfg      | cfg_write (no wait)       | cfg_index, cfg_data
//
//  One request per cycle while the output is not stalled; the result register loads from the update stage.
//  Rate is set by the single table memory: read on accept, write back from the
//  update stage, with a bypass for the same key on consecutive requests.
//  After reset a clearing pass over all TABLE_ENTRIES (1024) entries holds
//  in_ready low; configuration writes are taken throughout.
//  A stalled output holds one request in the update stage, then in_ready drops.
module per_key_fixed_window_rate_limiter_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [fwrl_pkg::KEY_W-1:0]   key_index,
    input  logic [fwrl_pkg::TIME_W-1:0]  now_seconds,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         allowed,
    output logic [fwrl_pkg::CNT_W-1:0]   count_in_window,
    input  logic                         cfg_write,
    input  logic [fwrl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fwrl_pkg::CFG_W-1:0]   cfg_data
);

    fwrl_pkg::state_t state_reg, state_next;
    logic [fwrl_pkg::IDX_W-1:0] clr_addr_reg, clr_addr_next;

    logic [fwrl_pkg::CFG_W-1:0] window_reg, limit_reg;

    fwrl_pkg::entry_t mem [fwrl_pkg::TABLE_ENTRIES];
    fwrl_pkg::entry_t rd_data_reg;
    fwrl_pkg::entry_t fwd_data_reg;
    logic             fwd_hit_reg;

    logic                        s1_valid_reg;
    logic [fwrl_pkg::IDX_W-1:0]  s1_slot_reg;
    logic [fwrl_pkg::TIME_W-1:0] s1_now_reg;

    logic                        out_valid_reg;
    logic                        allowed_reg;
    logic [fwrl_pkg::CNT_W-1:0]  count_reg;

    logic                        accept;
    logic                        out_load;
    logic                        s1_fire;
    logic [fwrl_pkg::IDX_W-1:0]  in_slot;

    fwrl_pkg::entry_t            cur;
    fwrl_pkg::entry_t            upd;
    logic                        upd_allowed;
    logic [fwrl_pkg::CNT_W-1:0]  limit_eff;
    logic [fwrl_pkg::TIME_W:0]   window_end;
    logic                        expired;

    logic                        mem_we;
    logic [fwrl_pkg::IDX_W-1:0]  mem_waddr;
    fwrl_pkg::entry_t            mem_wdata;

    assign in_slot  = fwrl_pkg::IDX_W'(key_index);
    assign out_load = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && out_load;
    assign accept   = in_valid && in_ready;

    // Sequencer: clearing pass, then normal running
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        in_ready      = 1'b0;
        unique case (state_reg)
            fwrl_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == fwrl_pkg::IDX_W'(fwrl_pkg::TABLE_ENTRIES - 1))
                begin
                    state_next = fwrl_pkg::ST_RUN;
                end
            end
            fwrl_pkg::ST_RUN:
            begin
                in_ready = !s1_valid_reg || s1_fire;
            end
            default:
            begin
                state_next = fwrl_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fwrl_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= fwrl_pkg::WINDOW_RESET;
            limit_reg  <= fwrl_pkg::LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fwrl_pkg::REG_WINDOW: window_reg <= cfg_data;
                fwrl_pkg::REG_LIMIT:  limit_reg  <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Update stage
    always_comb
    begin
        cur         = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        limit_eff   = (limit_reg == '0) ? fwrl_pkg::CNT_W'(1) : limit_reg;
        window_end  = {1'b0, cur.start} + (fwrl_pkg::TIME_W + 1)'(window_reg);
        expired     = {1'b0, s1_now_reg} > window_end;
        upd         = cur;
        upd_allowed = 1'b1;
        if (!cur.valid || expired)
        begin
            upd.valid = 1'b1;
            upd.start = s1_now_reg;
            upd.count = fwrl_pkg::CNT_W'(1);
        end
        else if (cur.count >= limit_eff)
        begin
            upd_allowed = 1'b0;
        end
        else
        begin
            upd.count = cur.count + 1'b1;
        end
    end

    always_comb
    begin
        if (state_reg == fwrl_pkg::ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = s1_fire;
            mem_waddr = s1_slot_reg;
            mem_wdata = upd;
        end
    end

    // Table memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rd_data_reg <= mem[in_slot];
        end
    end

    // Bypass of a write-back to the key being read in the same cycle, update stage inputs and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_data_reg <= upd;
            s1_slot_reg  <= in_slot;
            s1_now_reg   <= now_seconds;
        end
        if (s1_fire)
        begin
            allowed_reg <= upd_allowed;
            count_reg   <= upd.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= s1_fire && (s1_slot_reg == in_slot);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_fire;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign allowed         = allowed_reg;
    assign count_in_window = count_reg;

endmodule

// ===== hdl/fwrl_checker.sv =====
// ----------------------------------------------------------------------------
// Rate limiter port checker
// Watches the top-level ports for result and stall behaviour.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fwrl_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           allowed,
    input logic [fwrl_pkg::CNT_W-1:0]     count_in_window
);

    logic out_stall;
    logic in_xfer;

    assign out_stall = out_valid && !out_ready;
    assign in_xfer   = in_valid && in_ready;

    // stalled result stays put
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall,
        out_valid && $stable(allowed) && $stable(count_in_window))

    // every result carries a non-zero count, passed or refused
    `ASSERT_SAME(a_count_nonzero, clk, rst_n, out_valid, count_in_window != '0)

    // one request parked behind a stalled result blocks the next transfer
    `ASSERT_SAME(a_stall_blocks, clk, rst_n, $past(in_xfer) && out_stall, !in_ready)

endmodule

bind per_key_fixed_window_rate_limiter_core fwrl_checker u_fwrl_checker (.*);
